// ===== rtl/pps_pkg.sv =====
`default_nettype none

package pps_pkg;

    localparam int MAX_PROCS_DEF = 32;

    localparam int ARR_W  = 16;
    localparam int BUR_W  = 8;
    localparam int PRI_W  = 8;
    localparam int TIME_W = 17;
    localparam int PIDX_W = 5;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // one stored process as written at load
    typedef struct packed {
        logic [ARR_W-1:0] arr;
        logic [BUR_W-1:0] bur;
        logic [PRI_W-1:0] prio;
    } t_proc;

    // outcome of one pass over the process table
    typedef struct packed {
        logic              found;
        logic [ARR_W-1:0]  arr;
        logic [TIME_W-1:0] min_arr;
    } t_scan_res;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_SCAN_END,
        S_RUN,
        S_UPDATE,
        S_OREAD,
        S_OWAIT,
        S_OSEND
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/pps_store.sv =====
`default_nettype none

module pps_store #(
    parameter int DEPTH = pps_pkg::MAX_PROCS_DEF,
    parameter int IDX_W = 5
) (
    input  wire logic                       i_clk,
    // process table
    input  wire logic                       i_ap_we,
    input  wire logic [IDX_W-1:0]           i_ap_waddr,
    input  wire pps_pkg::t_proc             i_ap_wdata,
    input  wire logic                       i_ap_re,
    input  wire logic [IDX_W-1:0]           i_ap_raddr,
    output      pps_pkg::t_proc             o_ap_rdata,
    // remaining service
    input  wire logic                       i_rem_we,
    input  wire logic [IDX_W-1:0]           i_rem_waddr,
    input  wire logic [pps_pkg::BUR_W-1:0]  i_rem_wdata,
    input  wire logic                       i_rem_re,
    input  wire logic [IDX_W-1:0]           i_rem_raddr,
    output      logic [pps_pkg::BUR_W-1:0]  o_rem_rdata,
    // turnaround
    input  wire logic                       i_ta_we,
    input  wire logic [IDX_W-1:0]           i_ta_waddr,
    input  wire logic [pps_pkg::TIME_W-1:0] i_ta_wdata,
    input  wire logic                       i_ta_re,
    input  wire logic [IDX_W-1:0]           i_ta_raddr,
    output      logic [pps_pkg::TIME_W-1:0] o_ta_rdata
);

    pps_pkg::t_proc             r_ap_mem  [DEPTH];
    logic [pps_pkg::BUR_W-1:0]  r_rem_mem [DEPTH];
    logic [pps_pkg::TIME_W-1:0] r_ta_mem  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ap_we) begin
            r_ap_mem[i_ap_waddr] <= i_ap_wdata;
        end
        if (i_ap_re) begin
            o_ap_rdata <= r_ap_mem[i_ap_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rem_we) begin
            r_rem_mem[i_rem_waddr] <= i_rem_wdata;
        end
        if (i_rem_re) begin
            o_rem_rdata <= r_rem_mem[i_rem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ta_we) begin
            r_ta_mem[i_ta_waddr] <= i_ta_wdata;
        end
        if (i_ta_re) begin
            o_ta_rdata <= r_ta_mem[i_ta_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pps_scan.sv =====
`default_nettype none

module pps_scan #(
    parameter int IDX_W = 5
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_clr,
    input  wire logic                       i_vld,
    input  wire logic [IDX_W-1:0]           i_idx,
    input  wire logic                       i_fin,
    input  wire logic [pps_pkg::ARR_W-1:0]  i_arr,
    input  wire logic [pps_pkg::PRI_W-1:0]  i_prio,
    input  wire logic [pps_pkg::TIME_W-1:0] i_sim_time,
    output      pps_pkg::t_scan_res         o_res,
    output      logic [IDX_W-1:0]           o_idx
);

    logic                       r_found;
    logic [IDX_W-1:0]           r_idx;
    logic [pps_pkg::ARR_W-1:0]  r_arr;
    logic [pps_pkg::PRI_W-1:0]  r_prio;
    logic [pps_pkg::TIME_W-1:0] r_min_arr;

    logic [pps_pkg::TIME_W-1:0] w_arr_ext;
    logic                       w_ready;
    logic                       w_take;
    logic                       w_new_min;

    assign w_arr_ext = pps_pkg::TIME_W'(i_arr);
    assign w_ready   = !i_fin && (w_arr_ext <= i_sim_time);
    // strict compare keeps the lowest index on equal priority
    assign w_take    = i_vld && w_ready && (!r_found || (i_prio < r_prio));
    assign w_new_min = i_vld && !i_fin && (w_arr_ext < r_min_arr);

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_found   <= 1'b0;
            r_min_arr <= pps_pkg::TIME_MAX;
        end else begin
            if (w_take) begin
                r_found <= 1'b1;
            end
            if (w_new_min) begin
                r_min_arr <= w_arr_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_idx  <= i_idx;
            r_arr  <= i_arr;
            r_prio <= i_prio;
        end
    end

    assign o_res.found   = r_found;
    assign o_res.arr     = r_arr;
    assign o_res.min_arr = r_min_arr;
    assign o_idx         = r_idx;

endmodule

`default_nettype wire

// ===== rtl/preemptive_priority_scheduler.sv =====
`default_nettype none

// Preemptive priority scheduler. Processes are loaded one transaction per cycle
// (arrival, burst, priority); the transaction flagged last_process starts a
// unit-step simulation over the loaded set, always serving the arrived,
// unfinished process with the lowest priority value (lowest index on ties).
// After every process completes, one result transaction per process is sent
// in load order with turnaround and waiting times, last_result on the final
// one, and the block returns to loading. Each simulated time unit with work
// takes one pass of the shared compare unit over the process table (one
// entry per cycle through the table memory's read port, then the last
// entry's read data goes through the compare), then a read of the chosen
// process's remaining service and a write back of it. An idle gap before
// the next arrival is skipped in one pass. Each result is read through the
// registered reads of the table and turnaround memories, and the next one
// is not read until the current one is taken.
// o_stall is high from the start of simulation until the last result is taken.

module preemptive_priority_scheduler #(
    parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // process input channel
    input  wire logic                       i_valid,
    output      logic                       o_stall,
    input  wire logic [pps_pkg::ARR_W-1:0]  i_arrival_time,
    input  wire logic [pps_pkg::BUR_W-1:0]  i_burst_length,
    input  wire logic [pps_pkg::PRI_W-1:0]  i_priority_level,
    input  wire logic                       i_last_process,
    // result output channel
    output      logic                       o_valid,
    input  wire logic                       i_stall,
    output      logic [pps_pkg::PIDX_W-1:0] o_process_index,
    output      logic [pps_pkg::TIME_W-1:0] o_waiting_time,
    output      logic [pps_pkg::TIME_W-1:0] o_turnaround_time,
    output      logic                       o_last_result
);

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    // sequencer state
    pps_pkg::t_state r_state;
    pps_pkg::t_state n_state;

    // control registers
    logic [CNT_W-1:0]           r_load_cnt;
    logic [CNT_W-1:0]           r_done_cnt;
    logic [pps_pkg::TIME_W-1:0] r_sim_time;
    logic [MAX_PROCS-1:0]       r_fin;
    logic [IDX_W-1:0]           r_scan_idx;
    logic                       r_rd_vld;
    logic [IDX_W-1:0]           r_rd_idx;
    logic [IDX_W-1:0]           r_out_idx;
    logic                       r_o_valid;

    // output payload registers
    logic [IDX_W-1:0]           r_o_idx;
    logic [pps_pkg::TIME_W-1:0] r_o_wait;
    logic [pps_pkg::TIME_W-1:0] r_o_ta;
    logic                       r_o_last;

    // sequencer outputs
    logic                       w_in_acc;
    logic                       w_ap_re;
    logic [IDX_W-1:0]           w_ap_raddr;
    logic                       w_rem_re;
    logic                       w_scan_clr;
    logic                       w_upd;

    // datapath
    pps_pkg::t_proc             w_ap_wdata;
    pps_pkg::t_proc             w_ap_rdata;
    logic [pps_pkg::BUR_W-1:0]  w_rem_rdata;
    logic [pps_pkg::TIME_W-1:0] w_ta_rdata;
    pps_pkg::t_scan_res         w_sres;
    logic [IDX_W-1:0]           w_pick_idx;
    logic [CNT_W-1:0]           w_last_cnt;
    logic                       w_room;
    logic                       w_scan_last;
    logic                       w_out_last;
    logic [pps_pkg::BUR_W-1:0]  w_rem_new;
    logic                       w_finish;
    logic [pps_pkg::TIME_W-1:0] w_sim_next;
    logic [pps_pkg::TIME_W-1:0] w_ta_new;
    logic                       w_all_done;
    logic [pps_pkg::TIME_W-1:0] w_bur_ext;
    logic [pps_pkg::TIME_W-1:0] w_wait;
    logic [IDX_W+pps_pkg::PIDX_W-1:0] w_pidx_ext;

    assign w_last_cnt  = r_load_cnt - CNT_W'(1);
    assign w_room      = r_load_cnt < CNT_W'(MAX_PROCS);
    assign w_scan_last = CNT_W'(r_scan_idx) == w_last_cnt;
    assign w_out_last  = CNT_W'(r_out_idx) == w_last_cnt;

    // a zero burst is served as one unit
    assign w_ap_wdata.arr  = i_arrival_time;
    assign w_ap_wdata.bur  = (i_burst_length == '0) ? pps_pkg::BUR_W'(1) : i_burst_length;
    assign w_ap_wdata.prio = i_priority_level;

    // service step for the chosen process
    assign w_rem_new  = w_rem_rdata - pps_pkg::BUR_W'(1);
    assign w_finish   = (w_rem_new == '0);
    assign w_sim_next = (r_sim_time == pps_pkg::TIME_MAX) ? r_sim_time
                                                          : r_sim_time + pps_pkg::TIME_W'(1);
    assign w_ta_new   = w_sim_next - pps_pkg::TIME_W'(w_sres.arr);
    assign w_all_done = (r_done_cnt + CNT_W'(1)) == r_load_cnt;

    // result values
    assign w_bur_ext  = pps_pkg::TIME_W'(w_ap_rdata.bur);
    assign w_wait     = (w_ta_rdata >= w_bur_ext) ? (w_ta_rdata - w_bur_ext) : '0;
    assign w_pidx_ext = {{pps_pkg::PIDX_W{1'b0}}, r_o_idx};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pps_pkg::S_LOAD: begin
                if (i_valid && i_last_process) begin
                    n_state = pps_pkg::S_SCAN;
                end
            end
            pps_pkg::S_SCAN: begin
                if (w_scan_last) begin
                    n_state = pps_pkg::S_SCAN_END;
                end
            end
            pps_pkg::S_SCAN_END: begin
                n_state = pps_pkg::S_RUN;
            end
            pps_pkg::S_RUN: begin
                // no ready process: time jumps to the next arrival and we rescan
                n_state = w_sres.found ? pps_pkg::S_UPDATE : pps_pkg::S_SCAN;
            end
            pps_pkg::S_UPDATE: begin
                n_state = (w_finish && w_all_done) ? pps_pkg::S_OREAD : pps_pkg::S_SCAN;
            end
            pps_pkg::S_OREAD: begin
                n_state = pps_pkg::S_OWAIT;
            end
            pps_pkg::S_OWAIT: begin
                n_state = pps_pkg::S_OSEND;
            end
            pps_pkg::S_OSEND: begin
                if (!i_stall) begin
                    n_state = w_out_last ? pps_pkg::S_LOAD : pps_pkg::S_OREAD;
                end
            end
            default: begin
                n_state = pps_pkg::S_LOAD;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_stall    = 1'b1;
        w_ap_re    = 1'b0;
        w_ap_raddr = r_scan_idx;
        w_rem_re   = 1'b0;
        w_scan_clr = 1'b0;
        w_upd      = 1'b0;
        unique case (r_state)
            pps_pkg::S_LOAD: begin
                o_stall = 1'b0;
            end
            pps_pkg::S_SCAN: begin
                w_ap_re    = 1'b1;
                w_scan_clr = (r_scan_idx == '0);
            end
            pps_pkg::S_RUN: begin
                w_rem_re = w_sres.found;
            end
            pps_pkg::S_UPDATE: begin
                w_upd = 1'b1;
            end
            pps_pkg::S_OREAD: begin
                w_ap_re    = 1'b1;
                w_ap_raddr = r_out_idx;
            end
            pps_pkg::S_SCAN_END, pps_pkg::S_OWAIT, pps_pkg::S_OSEND: begin
            end
            default: begin
            end
        endcase
    end

    assign w_in_acc = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pps_pkg::S_LOAD;
            r_load_cnt <= '0;
            r_done_cnt <= '0;
            r_sim_time <= '0;
            r_fin      <= '0;
            r_scan_idx <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_idx   <= '0;
            r_out_idx  <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == pps_pkg::S_SCAN);
            r_rd_idx <= r_scan_idx;

            if (r_state == pps_pkg::S_SCAN) begin
                r_scan_idx <= r_scan_idx + IDX_W'(1);
            end else begin
                r_scan_idx <= '0;
            end

            // a process beyond the table size is dropped
            if (w_in_acc && w_room) begin
                r_fin[r_load_cnt[IDX_W-1:0]] <= 1'b0;
                r_load_cnt <= r_load_cnt + CNT_W'(1);
            end

            if (r_state == pps_pkg::S_LOAD) begin
                r_out_idx <= '0;
            end

            if ((r_state == pps_pkg::S_RUN) && !w_sres.found) begin
                r_sim_time <= w_sres.min_arr;
            end

            if (w_upd) begin
                r_sim_time <= w_sim_next;
                if (w_finish) begin
                    r_fin[w_pick_idx] <= 1'b1;
                    r_done_cnt        <= r_done_cnt + CNT_W'(1);
                end
            end

            if (r_state == pps_pkg::S_OWAIT) begin
                r_o_valid <= 1'b1;
            end

            if ((r_state == pps_pkg::S_OSEND) && !i_stall) begin
                r_o_valid <= 1'b0;
                if (w_out_last) begin
                    // set done: ready for a fresh set from time zero
                    r_load_cnt <= '0;
                    r_done_cnt <= '0;
                    r_sim_time <= '0;
                    r_fin      <= '0;
                end else begin
                    r_out_idx <= r_out_idx + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pps_pkg::S_OWAIT) begin
            r_o_idx  <= r_out_idx;
            r_o_ta   <= w_ta_rdata;
            r_o_wait <= w_wait;
            r_o_last <= w_out_last;
        end
    end

    pps_store #(
        .DEPTH (MAX_PROCS),
        .IDX_W (IDX_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_ap_we     (w_in_acc && w_room),
        .i_ap_waddr  (r_load_cnt[IDX_W-1:0]),
        .i_ap_wdata  (w_ap_wdata),
        .i_ap_re     (w_ap_re),
        .i_ap_raddr  (w_ap_raddr),
        .o_ap_rdata  (w_ap_rdata),
        .i_rem_we    ((w_in_acc && w_room) || w_upd),
        .i_rem_waddr (w_upd ? w_pick_idx : r_load_cnt[IDX_W-1:0]),
        .i_rem_wdata (w_upd ? w_rem_new : w_ap_wdata.bur),
        .i_rem_re    (w_rem_re),
        .i_rem_raddr (w_pick_idx),
        .o_rem_rdata (w_rem_rdata),
        .i_ta_we     (w_upd && w_finish),
        .i_ta_waddr  (w_pick_idx),
        .i_ta_wdata  (w_ta_new),
        .i_ta_re     (r_state == pps_pkg::S_OREAD),
        .i_ta_raddr  (r_out_idx),
        .o_ta_rdata  (w_ta_rdata)
    );

    // one table entry per cycle through the shared compare unit
    pps_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .i_clk      (i_clk),
        .i_clr      (w_scan_clr),
        .i_vld      (r_rd_vld),
        .i_idx      (r_rd_idx),
        .i_fin      (r_fin[r_rd_idx]),
        .i_arr      (w_ap_rdata.arr),
        .i_prio     (w_ap_rdata.prio),
        .i_sim_time (r_sim_time),
        .o_res      (w_sres),
        .o_idx      (w_pick_idx)
    );

    assign o_valid           = r_o_valid;
    assign o_process_index   = w_pidx_ext[pps_pkg::PIDX_W-1:0];
    assign o_waiting_time    = r_o_wait;
    assign o_turnaround_time = r_o_ta;
    assign o_last_result     = r_o_last;

    // no new process is taken while a result is pending
    a_no_load_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input accepted while a result is pending");

    // completions never outrun the loaded set
    a_done_le_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done_cnt <= r_load_cnt)
        else $error("completed count exceeds loaded count");

    // a service step always has a chosen process behind it
    a_update_has_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pps_pkg::S_UPDATE) |-> w_sres.found)
        else $error("service step without a ready process");

    // the last result carries the last loaded index
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_result) |-> (CNT_W'(r_out_idx) == w_last_cnt))
        else $error("last result flag on wrong process");

    // taking the last result empties the set
    a_set_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_result) |=> (r_load_cnt == '0))
        else $error("set not cleared after final result");

endmodule

`default_nettype wire
